[rtl/undirected_graph_store_top_assert.svh]
// Assertion macros for the undirected graph store.
// Included by the top level; no other dependencies.
`ifndef UNDIRECTED_GRAPH_STORE_TOP_ASSERT_SVH
`define UNDIRECTED_GRAPH_STORE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define UGS_ASSERT_IMPLY(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("undirected graph store: same-cycle check failed");
`define UGS_ASSERT_NEXT(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("undirected graph store: next-cycle check failed");
`else
`define UGS_ASSERT_IMPLY(name, ck, rstn, ante, cons)
`define UGS_ASSERT_NEXT(name, ck, rstn, ante, cons)
`endif
`endif

[rtl/ugs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the undirected graph store.
// No dependencies.
package ugs_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int ID_BITS_DEF   = 64;
  localparam int REQ_W         = 3;
  localparam int STATUS_W      = 3;
  localparam int FIELD_ID_W    = 64;

  localparam logic [REQ_W-1:0] REQ_ADD_NODE = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_ADD_EDGE = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_REM_NODE = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_REM_EDGE = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_GET_NODE = REQ_W'(4);
  localparam logic [REQ_W-1:0] REQ_GET_EDGE = REQ_W'(5);

  localparam logic [STATUS_W-1:0] STAT_ERROR   = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_DONE    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_FALSE   = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] STAT_PRESENT = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] STAT_FULL    = STATUS_W'(4);

  typedef enum logic [1:0] {
    ADJ_ZERO,
    ADJ_SET,
    ADJ_CLEAR
  } adj_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_ROW_WR,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_RESP
  } ugs_state_t;

  typedef struct packed {
    logic clr;
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } slot_cmd_t;

  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    adj_op_t op;
  } adj_cmd_t;

  typedef struct packed {
    logic a_found;
    logic b_found;
    logic free_found;
  } slot_hit_t;

endpackage

[rtl/undirected_graph_store_top.sv]
`timescale 1ns / 1ps
// Undirected graph store, top level: sequencer, slot table and adjacency matrix.
// Depends on ugs_pkg, ugs_seq, ugs_slot_table, ugs_adj_matrix and the assertion header.
// After reset the block runs a clearing pass over every entry of the slot table and the
// adjacency memory with in_ready low. Each request is then handled alone: the id lookup walks the
// slot table one entry per cycle through its single read port, and ST_SCAN_END and ST_DECIDE
// follow before the status word is offered. Node adds, node queries and rejected requests
// finish there; edge requests add the ROW_RD, ROW_CHK and, when the row changes, ROW_WR states
// on the adjacency row memory; removing a node walks every adjacency row once more. The next
// word is taken once the status word has been accepted.
`include "undirected_graph_store_top_assert.svh"
module undirected_graph_store_top #(
  parameter int MAX_NODES = ugs_pkg::MAX_NODES_DEF,
  parameter int ID_BITS   = ugs_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ugs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [ugs_pkg::FIELD_ID_W-1:0] in_first_id,
  input  logic [ugs_pkg::FIELD_ID_W-1:0] in_second_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ugs_pkg::STATUS_W-1:0]   out_status
);
  import ugs_pkg::*;

  localparam int IW = $clog2(MAX_NODES);

  slot_cmd_t          slot_cmd;
  slot_hit_t          hit;
  adj_cmd_t           adj_cmd;
  logic [IW-1:0]      slot_rd_addr;
  logic [IW-1:0]      slot_wr_addr;
  logic [IW-1:0]      a_idx;
  logic [IW-1:0]      b_idx;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      adj_rd_addr;
  logic [IW-1:0]      adj_wr_addr;
  logic [IW-1:0]      adj_col;
  logic [ID_BITS-1:0] ida;
  logic [ID_BITS-1:0] idb;
  logic               row_bit;

  ugs_seq #(
    .MAX_NODES (MAX_NODES),
    .ID_BITS   (ID_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_first_id  (in_first_id),
    .in_second_id (in_second_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .slot_cmd     (slot_cmd),
    .slot_rd_addr (slot_rd_addr),
    .slot_wr_addr (slot_wr_addr),
    .ida          (ida),
    .idb          (idb),
    .hit          (hit),
    .a_idx        (a_idx),
    .b_idx        (b_idx),
    .free_idx     (free_idx),
    .adj_cmd      (adj_cmd),
    .adj_rd_addr  (adj_rd_addr),
    .adj_wr_addr  (adj_wr_addr),
    .adj_col      (adj_col),
    .row_bit      (row_bit)
  );

  ugs_slot_table #(
    .MAX_NODES (MAX_NODES),
    .ID_BITS   (ID_BITS)
  ) u_slot_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (slot_cmd),
    .rd_addr  (slot_rd_addr),
    .wr_addr  (slot_wr_addr),
    .ida      (ida),
    .idb      (idb),
    .hit      (hit),
    .a_idx    (a_idx),
    .b_idx    (b_idx),
    .free_idx (free_idx)
  );

  ugs_adj_matrix #(
    .MAX_NODES (MAX_NODES)
  ) u_adj_matrix (
    .clk     (clk),
    .cmd     (adj_cmd),
    .rd_addr (adj_rd_addr),
    .wr_addr (adj_wr_addr),
    .col     (adj_col),
    .row_bit (row_bit)
  );

  `UGS_ASSERT_IMPLY(a_resp_not_ready, clk, rst_n, out_valid, !in_ready)
  `UGS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
  `UGS_ASSERT_IMPLY(a_update_after_read, clk, rst_n, adj_cmd.wr_en && (adj_cmd.op != ADJ_ZERO), $past(adj_cmd.rd_en))
  `UGS_ASSERT_IMPLY(a_slot_wr_idle_scan, clk, rst_n, slot_cmd.wr_en, !slot_cmd.rd_en)

endmodule

[rtl/ugs_slot_table.sv]
`timescale 1ns / 1ps
// Slot table: id memory with valid flags and the id comparators for both ids.
// Depends on ugs_pkg.
module ugs_slot_table #(
  parameter int MAX_NODES = ugs_pkg::MAX_NODES_DEF,
  parameter int ID_BITS   = ugs_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ugs_pkg::slot_cmd_t           cmd,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic [ID_BITS-1:0]           ida,
  input  logic [ID_BITS-1:0]           idb,
  output ugs_pkg::slot_hit_t           hit,
  output logic [$clog2(MAX_NODES)-1:0] a_idx,
  output logic [$clog2(MAX_NODES)-1:0] b_idx,
  output logic [$clog2(MAX_NODES)-1:0] free_idx
);
  import ugs_pkg::*;

  localparam int IW = $clog2(MAX_NODES);

  logic [ID_BITS:0] mem [0:MAX_NODES-1];
  logic [ID_BITS:0] rd_q_r;
  logic             pend_r;
  logic [IW-1:0]    pidx_r;
  slot_hit_t        hit_r;
  logic [IW-1:0]    a_idx_r;
  logic [IW-1:0]    b_idx_r;
  logic [IW-1:0]    free_idx_r;
  logic             slot_used;
  logic             a_eq;
  logic             b_eq;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {cmd.wr_valid, ida};
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
    pidx_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_en;
    end
  end

  assign slot_used = rd_q_r[ID_BITS];
  assign a_eq      = slot_used && (rd_q_r[ID_BITS-1:0] == ida);
  assign b_eq      = slot_used && (rd_q_r[ID_BITS-1:0] == idb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (cmd.clr) begin
      hit_r <= '0;
    end else if (pend_r) begin
      if (a_eq && !hit_r.a_found) begin
        hit_r.a_found <= 1'b1;
        a_idx_r       <= pidx_r;
      end
      if (b_eq && !hit_r.b_found) begin
        hit_r.b_found <= 1'b1;
        b_idx_r       <= pidx_r;
      end
      if (!slot_used && !hit_r.free_found) begin
        hit_r.free_found <= 1'b1;
        free_idx_r       <= pidx_r;
      end
    end
  end

  assign hit      = hit_r;
  assign a_idx    = a_idx_r;
  assign b_idx    = b_idx_r;
  assign free_idx = free_idx_r;

endmodule

[rtl/ugs_adj_matrix.sv]
`timescale 1ns / 1ps
// Adjacency bit matrix: row memory and the shared single-bit row update unit.
// Depends on ugs_pkg.
module ugs_adj_matrix #(
  parameter int MAX_NODES = ugs_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  ugs_pkg::adj_cmd_t            cmd,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic [$clog2(MAX_NODES)-1:0] col,
  output logic                         row_bit
);
  import ugs_pkg::*;

  logic [MAX_NODES-1:0] mem [0:MAX_NODES-1];
  logic [MAX_NODES-1:0] row_q_r;
  logic [MAX_NODES-1:0] col_mask;
  logic [MAX_NODES-1:0] wr_row;

  assign col_mask = {{(MAX_NODES-1){1'b0}}, 1'b1} << col;

  always_comb begin
    case (cmd.op)
      ADJ_ZERO:  wr_row = '0;
      ADJ_SET:   wr_row = row_q_r | col_mask;
      ADJ_CLEAR: wr_row = row_q_r & ~col_mask;
      default:   wr_row = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd_en) begin
      row_q_r <= mem[rd_addr];
    end
  end

  assign row_bit = row_q_r[col];

endmodule

[rtl/ugs_seq.sv]
`timescale 1ns / 1ps
// Request sequencer: handshakes, clearing pass, slot scan and row walks.
// Depends on ugs_pkg.
module ugs_seq #(
  parameter int MAX_NODES = ugs_pkg::MAX_NODES_DEF,
  parameter int ID_BITS   = ugs_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ugs_pkg::REQ_W-1:0]        in_req_type,
  input  logic [ugs_pkg::FIELD_ID_W-1:0]   in_first_id,
  input  logic [ugs_pkg::FIELD_ID_W-1:0]   in_second_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ugs_pkg::STATUS_W-1:0]     out_status,
  output ugs_pkg::slot_cmd_t               slot_cmd,
  output logic [$clog2(MAX_NODES)-1:0]     slot_rd_addr,
  output logic [$clog2(MAX_NODES)-1:0]     slot_wr_addr,
  output logic [ID_BITS-1:0]               ida,
  output logic [ID_BITS-1:0]               idb,
  input  ugs_pkg::slot_hit_t               hit,
  input  logic [$clog2(MAX_NODES)-1:0]     a_idx,
  input  logic [$clog2(MAX_NODES)-1:0]     b_idx,
  input  logic [$clog2(MAX_NODES)-1:0]     free_idx,
  output ugs_pkg::adj_cmd_t                adj_cmd,
  output logic [$clog2(MAX_NODES)-1:0]     adj_rd_addr,
  output logic [$clog2(MAX_NODES)-1:0]     adj_wr_addr,
  output logic [$clog2(MAX_NODES)-1:0]     adj_col,
  input  logic                             row_bit
);
  import ugs_pkg::*;

  localparam int IW = $clog2(MAX_NODES);

  ugs_state_t           state_r;
  ugs_state_t           state_nxt;
  logic [IW-1:0]        cnt_r;
  logic [IW-1:0]        cnt_nxt;
  logic [STATUS_W-1:0]  status_r;
  logic [STATUS_W-1:0]  status_nxt;
  logic [REQ_W-1:0]     kind_r;
  logic [ID_BITS-1:0]   ida_r;
  logic [ID_BITS-1:0]   idb_r;
  logic                 sw_pend_r;
  logic [IW-1:0]        sw_idx_r;
  logic                 last;
  logic                 both_found;
  logic                 edge_write;

  assign last       = (cnt_r == IW'(MAX_NODES - 1));
  assign both_found = hit.a_found && hit.b_found;
  assign edge_write = ((kind_r == REQ_ADD_EDGE) && !row_bit) ||
                      ((kind_r == REQ_REM_EDGE) && row_bit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      sw_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      sw_pend_r <= (state_r == ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    sw_idx_r <= cnt_r;
    if (in_valid && in_ready) begin
      kind_r <= in_req_type;
      ida_r  <= in_first_id[ID_BITS-1:0];
      idb_r  <= in_second_id[ID_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (last) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:      if (last) state_nxt = ST_SCAN_END;
      ST_SCAN_END:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = ST_RESP;
        case (kind_r)
          REQ_ADD_EDGE: if (both_found && (ida_r != idb_r)) state_nxt = ST_ROW_RD;
          REQ_REM_NODE: if (hit.a_found) state_nxt = ST_SWEEP;
          REQ_REM_EDGE: if (both_found) state_nxt = ST_ROW_RD;
          REQ_GET_EDGE: if (both_found) state_nxt = ST_ROW_RD;
          default:      state_nxt = ST_RESP;
        endcase
      end
      ST_ROW_RD:    state_nxt = ST_ROW_CHK;
      ST_ROW_CHK:   state_nxt = edge_write ? ST_ROW_WR : ST_RESP;
      ST_ROW_WR:    state_nxt = ST_RESP;
      ST_SWEEP:     if (last) state_nxt = ST_SWEEP_END;
      ST_SWEEP_END: state_nxt = ST_RESP;
      ST_RESP:      if (out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cnt_nxt    = '0;
    status_nxt = status_r;
    case (state_r)
      ST_CLEAR, ST_SCAN, ST_SWEEP: begin
        cnt_nxt = last ? '0 : cnt_r + IW'(1);
      end
      ST_DECIDE: begin
        case (kind_r)
          REQ_ADD_NODE: begin
            if (hit.a_found) begin
              status_nxt = STAT_PRESENT;
            end else if (hit.free_found) begin
              status_nxt = STAT_DONE;
            end else begin
              status_nxt = STAT_FULL;
            end
          end
          REQ_GET_NODE: status_nxt = hit.a_found ? STAT_DONE : STAT_FALSE;
          default:      status_nxt = STAT_ERROR;
        endcase
      end
      ST_ROW_CHK: begin
        case (kind_r)
          REQ_ADD_EDGE: status_nxt = row_bit ? STAT_PRESENT : STAT_DONE;
          REQ_REM_EDGE: status_nxt = row_bit ? STAT_DONE : STAT_ERROR;
          REQ_GET_EDGE: status_nxt = row_bit ? STAT_DONE : STAT_FALSE;
          default:      status_nxt = STAT_ERROR;
        endcase
      end
      ST_SWEEP_END: status_nxt = STAT_DONE;
      default:      cnt_nxt = '0;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    out_valid    = (state_r == ST_RESP);
    slot_cmd     = '0;
    slot_rd_addr = cnt_r;
    slot_wr_addr = cnt_r;
    adj_cmd      = '{rd_en: 1'b0, wr_en: 1'b0, op: ADJ_ZERO};
    adj_rd_addr  = cnt_r;
    adj_wr_addr  = cnt_r;
    adj_col      = a_idx;
    case (state_r)
      ST_CLEAR: begin
        slot_cmd.wr_en = 1'b1;
        adj_cmd.wr_en  = 1'b1;
      end
      ST_IDLE: slot_cmd.clr = 1'b1;
      ST_SCAN: slot_cmd.rd_en = 1'b1;
      ST_DECIDE: begin
        slot_wr_addr      = free_idx;
        slot_cmd.wr_valid = 1'b1;
        slot_cmd.wr_en    = (kind_r == REQ_ADD_NODE) && !hit.a_found && hit.free_found;
      end
      ST_ROW_RD: begin
        adj_cmd.rd_en = 1'b1;
        adj_rd_addr   = a_idx;
      end
      ST_ROW_CHK: begin
        adj_col       = b_idx;
        adj_wr_addr   = a_idx;
        adj_rd_addr   = b_idx;
        adj_cmd.op    = (kind_r == REQ_ADD_EDGE) ? ADJ_SET : ADJ_CLEAR;
        adj_cmd.wr_en = edge_write;
        adj_cmd.rd_en = edge_write;
      end
      ST_ROW_WR: begin
        adj_wr_addr   = b_idx;
        adj_cmd.op    = (kind_r == REQ_ADD_EDGE) ? ADJ_SET : ADJ_CLEAR;
        adj_cmd.wr_en = 1'b1;
      end
      ST_SWEEP, ST_SWEEP_END: begin
        adj_cmd.rd_en = (state_r == ST_SWEEP);
        adj_wr_addr   = sw_idx_r;
        adj_cmd.wr_en = sw_pend_r;
        adj_cmd.op    = (sw_idx_r == a_idx) ? ADJ_ZERO : ADJ_CLEAR;
        slot_wr_addr  = a_idx;
        slot_cmd.wr_en = (state_r == ST_SWEEP_END);
      end
      default: begin
        slot_cmd = '0;
      end
    endcase
  end

  assign out_status = status_r;
  assign ida        = ida_r;
  assign idb        = idb_r;

endmodule

[tb/undirected_graph_store_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for undirected_graph_store_top: directed and random requests.
// Needs ugs_pkg and the RTL; an in-bench graph predictor checks each status word.
module undirected_graph_store_top_tb;
  import ugs_pkg::*;

  localparam int NODES    = MAX_NODES_DEF;
  localparam int POOL     = 80;
  localparam int HOT      = 12;
  localparam int ROUNDS   = 14;
  localparam int ROUND_SZ = 100;

  typedef enum int {
    MODE_GROW,
    MODE_MIXED,
    MODE_CHURN
  } round_mode_t;

  class graph_status_board;
    logic [FIELD_ID_W-1:0] node_id [NODES];
    bit                    node_live [NODES];
    bit [NODES-1:0]        links [NODES];
    logic [STATUS_W-1:0]   pending [$];
    int                    mismatches;
    int                    requests;
    int                    tally [8];

    function int slot_of(logic [FIELD_ID_W-1:0] id);
      for (int s = 0; s < NODES; s++) begin
        if (node_live[s] && node_id[s] == id) return s;
      end
      return -1;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [FIELD_ID_W-1:0] a_id,
                               logic [FIELD_ID_W-1:0] b_id);
      int                  a;
      int                  b;
      bit                  placed;
      logic [STATUS_W-1:0] st;
      a  = slot_of(a_id);
      b  = slot_of(b_id);
      st = STAT_ERROR;
      case (kind)
        REQ_ADD_NODE: begin
          if (a >= 0) begin
            st = STAT_PRESENT;
          end else begin
            st     = STAT_FULL;
            placed = 1'b0;
            for (int s = 0; s < NODES; s++) begin
              if (!placed && !node_live[s]) begin
                node_live[s] = 1'b1;
                node_id[s]   = a_id;
                links[s]     = '0;
                placed       = 1'b1;
                st           = STAT_DONE;
              end
            end
          end
        end
        REQ_ADD_EDGE: begin
          if (a_id == b_id || a < 0 || b < 0) begin
            st = STAT_ERROR;
          end else if (links[a][b]) begin
            st = STAT_PRESENT;
          end else begin
            links[a][b] = 1'b1;
            links[b][a] = 1'b1;
            st          = STAT_DONE;
          end
        end
        REQ_REM_NODE: begin
          if (a >= 0) begin
            for (int s = 0; s < NODES; s++) links[s][a] = 1'b0;
            links[a]     = '0;
            node_live[a] = 1'b0;
            st           = STAT_DONE;
          end
        end
        REQ_REM_EDGE: begin
          if (a >= 0 && b >= 0 && links[a][b]) begin
            links[a][b] = 1'b0;
            links[b][a] = 1'b0;
            st          = STAT_DONE;
          end
        end
        REQ_GET_NODE: begin
          st = (a >= 0) ? STAT_DONE : STAT_FALSE;
        end
        REQ_GET_EDGE: begin
          if (a >= 0 && b >= 0) st = links[a][b] ? STAT_DONE : STAT_FALSE;
        end
        default: begin
          st = STAT_ERROR;
        end
      endcase
      requests++;
      tally[st]++;
      pending.push_back(st);
    endfunction

    function void check_status(logic [STATUS_W-1:0] got);
      logic [STATUS_W-1:0] want;
      if (pending.size() == 0) begin
        $error("status word %0d arrived with nothing outstanding", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("status mismatch: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [REQ_W-1:0]      in_req_type  = REQ_GET_NODE;
  logic [FIELD_ID_W-1:0] in_first_id  = '0;
  logic [FIELD_ID_W-1:0] in_second_id = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [STATUS_W-1:0]   out_status;

  graph_status_board     board = new();
  logic [FIELD_ID_W-1:0] id_pool [POOL];
  int                    grow_cursor   = 0;
  bit                    quiet_stretch = 1'b0;

  undirected_graph_store_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_first_id (in_first_id),
    .in_second_id(in_second_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status)
  );

  always #6 clk = ~clk;

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [FIELD_ID_W-1:0] a_id,
                              input logic [FIELD_ID_W-1:0] b_id);
    if (!quiet_stretch && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 160)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_first_id  <= a_id;
    in_second_id <= b_id;
    do @(posedge clk); while (!in_ready);
    board.note_request(kind, a_id, b_id);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [FIELD_ID_W-1:0] pool_id();
    if ($urandom_range(0, 99) < 30) return id_pool[$urandom_range(0, HOT - 1)];
    return id_pool[$urandom_range(0, POOL - 1)];
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(round_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (roll < 55) return REQ_ADD_NODE;
        if (roll < 80) return REQ_ADD_EDGE;
        if (roll < 86) return REQ_GET_NODE;
        if (roll < 94) return REQ_GET_EDGE;
        if (roll < 97) return REQ_REM_EDGE;
        return REQ_REM_NODE;
      end
      MODE_CHURN: begin
        if (roll < 25) return REQ_REM_NODE;
        if (roll < 45) return REQ_REM_EDGE;
        if (roll < 65) return REQ_ADD_EDGE;
        if (roll < 80) return REQ_ADD_NODE;
        if (roll < 90) return REQ_GET_NODE;
        return REQ_GET_EDGE;
      end
      default: begin
        if (roll < 20) return REQ_ADD_NODE;
        if (roll < 45) return REQ_ADD_EDGE;
        if (roll < 55) return REQ_REM_NODE;
        if (roll < 70) return REQ_REM_EDGE;
        if (roll < 82) return REQ_GET_NODE;
        return REQ_GET_EDGE;
      end
    endcase
  endfunction

  task automatic random_request(input round_mode_t mode);
    logic [REQ_W-1:0]      kind;
    logic [FIELD_ID_W-1:0] a_id;
    logic [FIELD_ID_W-1:0] b_id;
    if ($urandom_range(0, 99) < 5) begin
      kind = REQ_W'($urandom_range(0, 7));
      a_id = {$urandom, $urandom};
      b_id = {$urandom, $urandom};
    end else begin
      kind = pick_kind(mode);
      if (mode == MODE_GROW && kind == REQ_ADD_NODE) begin
        a_id        = id_pool[grow_cursor % POOL];
        grow_cursor = grow_cursor + 1;
      end else begin
        a_id = pool_id();
      end
      b_id = ($urandom_range(0, 19) == 0) ? a_id : pool_id();
    end
    send_request(kind, a_id, b_id);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_status(out_status);
      out_ready <= quiet_stretch || ($urandom_range(0, 99) >= 30);
    end
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [FIELD_ID_W-1:0] base;
    logic [FIELD_ID_W-1:0] ones;
    logic [FIELD_ID_W-1:0] stray_id;
    round_mode_t           mode;

    base       = {$urandom, $urandom};
    ones       = '1;
    stray_id   = 64'h5555_5555_5555_5555;
    id_pool[0] = '0;
    id_pool[1] = ones;
    for (int i = 2; i < 66; i++) id_pool[i] = base ^ (64'd1 << (i - 2));
    for (int i = 66; i < POOL; i++) id_pool[i] = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_request(REQ_GET_NODE, '0, '0);
    send_request(REQ_REM_NODE, '0, '0);
    send_request(REQ_ADD_NODE, '0, ones);
    send_request(REQ_ADD_NODE, ones, '0);
    send_request(REQ_ADD_NODE, '0, stray_id);
    send_request(REQ_ADD_EDGE, '0, '0);
    send_request(REQ_GET_EDGE, '0, '0);
    send_request(REQ_ADD_EDGE, '0, ones);
    send_request(REQ_ADD_EDGE, ones, '0);
    send_request(REQ_GET_EDGE, ones, '0);
    send_request(REQ_ADD_EDGE, '0, stray_id);
    send_request(REQ_GET_EDGE, stray_id, '0);
    send_request(REQ_REM_EDGE, '0, '0);
    send_request(REQ_REM_EDGE, '0, ones);
    send_request(REQ_REM_EDGE, ones, '0);
    send_request(REQ_GET_EDGE, '0, ones);
    send_request(REQ_ADD_EDGE, ones, '0);
    send_request(REQ_REM_NODE, ones, stray_id);
    send_request(REQ_GET_NODE, ones, '0);
    send_request(REQ_GET_EDGE, '0, ones);
    send_request(REQ_W'(6), '0, '0);
    send_request(REQ_W'(7), ones, ones);
    send_request(REQ_GET_NODE, '0, ones);
    send_request(REQ_REM_NODE, '0, '0);
    send_request(REQ_GET_NODE, '0, '0);
    hold_until_drained();

    for (int r = 0; r < ROUNDS; r++) begin
      mode          = (r < 2) ? MODE_GROW : round_mode_t'(r % 3);
      quiet_stretch = (r == 5);
      for (int k = 0; k < ROUND_SZ; k++) random_request(mode);
      if (r % 4 == 3) hold_until_drained();
    end
    quiet_stretch = 1'b0;

    hold_until_drained();
    repeat (2 * NODES + 10) @(posedge clk);

    $display("Ran %0d requests through grow, mixed and churn rounds, table full included.",
             board.requests);
    $display("Status mix: %0d done/true, %0d false, %0d present, %0d full, %0d error.",
             board.tally[STAT_DONE], board.tally[STAT_FALSE], board.tally[STAT_PRESENT],
             board.tally[STAT_FULL], board.tally[STAT_ERROR]);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
